// ===== rtl/tcfifo_pkg.sv =====
// ----------------------------------------------------------------------------
// tcfifo_pkg
// Shared types and codes for the two-class oldest-first FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package tcfifo_pkg;

  localparam int SEQ_W    = 16;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH_A  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_B  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_ANY = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_A   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP_B   = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } tcfifo_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } tcfifo_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } tcfifo_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/tcfifo_ifs.sv =====
// ----------------------------------------------------------------------------
// tcfifo_ifs
// Valid/ready channel interfaces for operation requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcfifo_in_if #(
  parameter int TAG_WIDTH = 16
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           mode;
  logic [TAG_WIDTH-1:0] item_tag;

  modport source (output valid, output mode, output item_tag, input ready);
  modport sink   (input valid, input mode, input item_tag, output ready);
endinterface

interface tcfifo_out_if #(
  parameter int TAG_WIDTH = 16
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [TAG_WIDTH-1:0] out_tag;
  logic                 out_class;

  modport source (output valid, output status, output out_tag, output out_class,
                  input ready);
  modport sink   (input valid, input status, input out_tag, input out_class,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/tcfifo_queue.sv =====
// ----------------------------------------------------------------------------
// tcfifo_queue
// One circular FIFO with a memory store and a registered read of its head.
// ----------------------------------------------------------------------------
`default_nettype none

module tcfifo_queue #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  input  wire logic                      pop,
  input  wire logic [DATA_W-1:0]         wr_data,
  output      logic [DATA_W-1:0]         head_data,
  output      tcfifo_pkg::tcfifo_qstat_t qstat
);
  import tcfifo_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_r;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    head_nxt  = pop  ? advance(head_r) : head_r;
    tail_nxt  = push ? advance(tail_r) : tail_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[head_r];
  end

  assign head_data   = rd_r;
  assign qstat.empty = (count_r == '0);
  assign qstat.full  = (count_r == CNT_W'(DEPTH));

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("push into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("pop from an empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("count did not advance on push");

endmodule

`default_nettype wire

// ===== rtl/tcfifo_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcfifo_ctrl
// Sequencer: accept an operation, execute it, present the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tcfifo_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output      logic                    in_ready,
  output      logic                    out_valid,
  input  wire logic                    out_ready,
  output      tcfifo_pkg::tcfifo_cmd_t cmd
);
  import tcfifo_pkg::*;

  tcfifo_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec)
    else $error("execute did not follow accept");

  a_resp_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("result not presented after execute");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("accepting while a result is pending");

endmodule

`default_nettype wire

// ===== rtl/tcfifo_dp.sv =====
// ----------------------------------------------------------------------------
// tcfifo_dp
// Datapath: operation registers, arrival counter, both class queues,
// oldest-head selection and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcfifo_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_WIDTH   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tcfifo_pkg::tcfifo_cmd_t       cmd,
  input  wire logic [tcfifo_pkg::MODE_W-1:0] in_mode,
  input  wire logic [TAG_WIDTH-1:0]          in_tag,
  output      logic [tcfifo_pkg::STATUS_W-1:0] res_status,
  output      logic [TAG_WIDTH-1:0]          res_tag,
  output      logic                          res_class
);
  import tcfifo_pkg::*;

  localparam int ENTRY_W = TAG_WIDTH + SEQ_W;

  logic [MODE_W-1:0]    mode_r;
  logic [TAG_WIDTH-1:0] tag_r;
  logic [SEQ_W-1:0]     arrival_r, arrival_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [TAG_WIDTH-1:0] otag_r, otag_nxt;
  logic                 ocls_r, ocls_nxt;

  logic                 push_a, push_b, pop_a, pop_b;
  logic [ENTRY_W-1:0]   head_a, head_b;
  tcfifo_qstat_t        qs_a, qs_b;
  logic [SEQ_W-1:0]     seq_diff;
  logic                 take_a;

  tcfifo_queue #(.DEPTH(QUEUE_DEPTH), .DATA_W(ENTRY_W)) u_queue_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_a),
    .pop       (pop_a),
    .wr_data   ({tag_r, arrival_r}),
    .head_data (head_a),
    .qstat     (qs_a)
  );

  tcfifo_queue #(.DEPTH(QUEUE_DEPTH), .DATA_W(ENTRY_W)) u_queue_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_b),
    .pop       (pop_b),
    .wr_data   ({tag_r, arrival_r}),
    .head_data (head_b),
    .qstat     (qs_b)
  );

  // Head A is older when the wrapped stamp difference is negative.
  assign seq_diff = head_a[SEQ_W-1:0] - head_b[SEQ_W-1:0];
  assign take_a   = qs_b.empty || (!qs_a.empty && seq_diff[SEQ_W-1]);

  always_comb begin
    push_a      = 1'b0;
    push_b      = 1'b0;
    pop_a       = 1'b0;
    pop_b       = 1'b0;
    status_nxt  = STAT_OK;
    otag_nxt    = '0;
    ocls_nxt    = 1'b0;
    arrival_nxt = arrival_r;
    unique case (mode_r)
      MODE_PUSH_A: begin
        if (qs_a.full) begin
          status_nxt = STAT_FULL;
        end else begin
          push_a = cmd.exec;
        end
      end
      MODE_PUSH_B: begin
        ocls_nxt = 1'b1;
        if (qs_b.full) begin
          status_nxt = STAT_FULL;
        end else begin
          push_b = cmd.exec;
        end
      end
      MODE_POP_ANY: begin
        if (qs_a.empty && qs_b.empty) begin
          status_nxt = STAT_EMPTY;
        end else if (take_a) begin
          pop_a    = cmd.exec;
          otag_nxt = head_a[ENTRY_W-1:SEQ_W];
        end else begin
          pop_b    = cmd.exec;
          ocls_nxt = 1'b1;
          otag_nxt = head_b[ENTRY_W-1:SEQ_W];
        end
      end
      MODE_POP_A: begin
        if (qs_a.empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          pop_a    = cmd.exec;
          otag_nxt = head_a[ENTRY_W-1:SEQ_W];
        end
      end
      MODE_POP_B: begin
        ocls_nxt = 1'b1;
        if (qs_b.empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          pop_b    = cmd.exec;
          otag_nxt = head_b[ENTRY_W-1:SEQ_W];
        end
      end
      default: begin
        status_nxt = STAT_OK;
      end
    endcase
    if (push_a || push_b) begin
      arrival_nxt = arrival_r + SEQ_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrival_r <= SEQ_W'(1);
    end else begin
      arrival_r <= arrival_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      tag_r  <= in_tag;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      otag_r   <= otag_nxt;
      ocls_r   <= ocls_nxt;
    end
  end

  assign res_status = status_r;
  assign res_tag    = otag_r;
  assign res_class  = ocls_r;

  a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({push_a, push_b, pop_a, pop_b}) <= 1)
    else $error("more than one queue operation at once");

  a_ops_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (push_a || push_b || pop_a || pop_b) |-> cmd.exec)
    else $error("queue operation outside execute");

  a_counter_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_a || push_b) |=> $stable(arrival_r))
    else $error("arrival counter moved without a push");

endmodule

`default_nettype wire

// ===== rtl/two_class_fifo_oldest_first.sv =====
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_first
// Two class FIFOs sharing one arrival stamp, with oldest-first pop.
//
// An operation enters on in_ch (mode, item_tag) and one result leaves on
// out_ch (status, out_tag, out_class) for every operation. A transfer
// happens when valid and ready are both high at a rising clock edge.
// Modes push to class A or B, pop a given class, or pop whichever head
// was pushed first, judged by wrap-aware comparison of 16-bit stamps.
// Pops of an empty class report empty; pushes to a full class report full.
// After the input transfer the sequencer moves through its execute state
// to its result state, where out_ch.valid rises. A three-state
// sequencer accepts each operation, executes it against the queue
// memories, then holds the result register until the output transfer.
// While out_ch.ready is low the result is held and in_ch.ready stays
// low. Synchronous reset empties both queues and sets the arrival counter
// to one; stored entries keep their contents but are never used before
// being written.
// ----------------------------------------------------------------------------
`default_nettype none

module two_class_fifo_oldest_first #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_WIDTH   = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  tcfifo_in_if.sink    in_ch,
  tcfifo_out_if.source out_ch
);
  import tcfifo_pkg::*;

  tcfifo_cmd_t cmd;
  logic        in_ready;
  logic        out_valid;

  tcfifo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  tcfifo_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .TAG_WIDTH(TAG_WIDTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_mode    (in_ch.mode),
    .in_tag     (in_ch.item_tag),
    .res_status (out_ch.status),
    .res_tag    (out_ch.out_tag),
    .res_class  (out_ch.out_class)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire
